/* src/assert_macros.svh */
// shared assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen at a rising clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* src/wnm_pkg.sv */
package wnm_pkg;

    // pattern capacity and derived widths
    localparam int PATTERN_MAX_BYTES = 32;
    localparam int COL_W             = PATTERN_MAX_BYTES + 1;
    localparam int LEN_W             = $clog2(PATTERN_MAX_BYTES + 1);
    localparam int KS_LEVELS         = $clog2(COL_W);

    // configuration register layout
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_WORDS   = 4;
    localparam int WORD_SEL_W  = 2;
    localparam int PAT_LEN_W   = 6;
    localparam int PAT_FLAT_W  = CFG_WORDS * CFG_DATA_W;

    // glob characters
    localparam logic [7:0] GLOB_ANY_RUN = 8'h2A;
    localparam logic [7:0] GLOB_ONE     = 8'h3F;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH = 3'd0,
        CFG_PATTERN_WORD_0 = 3'd1,
        CFG_PATTERN_WORD_1 = 3'd2,
        CFG_PATTERN_WORD_2 = 3'd3,
        CFG_PATTERN_WORD_3 = 3'd4
    } t_cfg_index;

    typedef logic [COL_W-1:0] t_column;

endpackage

/* src/wildcard_name_match_top.sv */
// matched is registered into the output register, or into the skid entry while the output register is still held
// throughput: one name byte per cycle while the skid entry is free; the whole column update is one combinational pass
// a two-entry output stage (register plus skid) keeps input ready while a result waits
// reset (i_rst_n low, synchronous): pattern registers cleared, no name in progress,
// output stage empty
module wildcard_name_match_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [wnm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wnm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // name byte channel
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [7:0]                   i_name_byte,
    input  logic                         i_last_byte,
    // result channel
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_matched
);
    import wnm_pkg::*;

    `include "assert_macros.svh"

    // configuration registers
    logic [PAT_LEN_W-1:0]  r_pat_len;
    logic [CFG_DATA_W-1:0] r_pat_word [CFG_WORDS];

    // match state
    t_column r_col;
    logic    r_in_progress;

    // output stage
    logic r_out_valid;
    logic r_out_matched;
    logic r_skid_valid;
    logic r_skid_matched;

    logic                  in_xfer;
    logic                  out_xfer;
    logic                  push;
    logic [LEN_W-1:0]      len;
    logic [PAT_FLAT_W-1:0] pat_flat;
    t_column               len_mask;
    t_column               is_star;
    t_column               start_col;
    t_column               old_col;
    t_column               n_col;
    logic                  n_matched;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !r_skid_valid;
    assign o_valid     = r_out_valid;
    assign o_matched   = r_out_matched;
    assign in_xfer     = i_valid && o_ready;
    assign out_xfer    = r_out_valid && i_ready;
    assign push        = in_xfer && i_last_byte;

    // configuration write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len <= '0;
            for (int w = 0; w < CFG_WORDS; w++) begin
                r_pat_word[w] <= '0;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index) inside
                CFG_PATTERN_LENGTH: begin
                    r_pat_len <= i_cfg_data[PAT_LEN_W-1:0];
                end
                CFG_PATTERN_WORD_0, CFG_PATTERN_WORD_1,
                CFG_PATTERN_WORD_2, CFG_PATTERN_WORD_3: begin
                    r_pat_word[WORD_SEL_W'(i_cfg_index - CFG_PATTERN_WORD_0)] <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // saturated length and pattern byte classes
    always_comb begin
        len = (r_pat_len > PAT_LEN_W'(PATTERN_MAX_BYTES)) ?
              LEN_W'(PATTERN_MAX_BYTES) : r_pat_len[LEN_W-1:0];
        pat_flat = {r_pat_word[3], r_pat_word[2], r_pat_word[1], r_pat_word[0]};
        len_mask = '0;
        is_star  = '0;
        for (int i = 0; i < COL_W; i++) begin
            len_mask[i] = (LEN_W'(i) <= len);
        end
        for (int i = 1; i < COL_W; i++) begin
            is_star[i] = (pat_flat[(i - 1) * 8 +: 8] == GLOB_ANY_RUN);
        end
    end

    // start column: empty prefix plus every all-star prefix
    always_comb begin
        start_col    = '0;
        start_col[0] = 1'b1;
        for (int i = 1; i < COL_W; i++) begin
            start_col[i] = len_mask[i] &&
                           ((is_star | ~(t_column'((t_column'(1) << (i + 1)) - 1))
                             | t_column'(1)) == '1);
        end
        old_col = r_in_progress ? r_col : start_col;
    end

    // column update: star rows chain upward, solved as a parallel prefix
    always_comb begin
        t_column gen [KS_LEVELS+1];
        t_column prop [KS_LEVELS+1];
        logic [7:0] pc;
        gen[0]  = '0;
        prop[0] = '0;
        for (int i = 1; i < COL_W; i++) begin
            pc = pat_flat[(i - 1) * 8 +: 8];
            if (is_star[i]) begin
                gen[0][i]  = old_col[i];
                prop[0][i] = 1'b1;
            end else if (pc == GLOB_ONE) begin
                gen[0][i] = old_col[i - 1];
            end else begin
                gen[0][i] = old_col[i - 1] && (pc == i_name_byte);
            end
        end
        for (int d = 0; d < KS_LEVELS; d++) begin
            for (int i = 0; i < COL_W; i++) begin
                if (i >= (1 << d)) begin
                    gen[d + 1][i]  = gen[d][i] | (prop[d][i] & gen[d][i - (1 << d)]);
                    prop[d + 1][i] = prop[d][i] & prop[d][i - (1 << d)];
                end else begin
                    gen[d + 1][i]  = gen[d][i];
                    prop[d + 1][i] = prop[d][i];
                end
            end
        end
        n_col     = gen[KS_LEVELS] & len_mask;
        n_matched = n_col[len];
    end

    // match state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col         <= '0;
            r_in_progress <= 1'b0;
        end else if (in_xfer) begin
            if (i_last_byte) begin
                r_col         <= '0;
                r_in_progress <= 1'b0;
            end else begin
                r_col         <= n_col;
                r_in_progress <= 1'b1;
            end
        end
    end

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_xfer) begin
                r_out_matched <= r_skid_matched;
                r_skid_valid  <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid || out_xfer) begin
                r_out_valid   <= 1'b1;
                r_out_matched <= n_matched;
            end else begin
                r_skid_valid   <= 1'b1;
                r_skid_matched <= n_matched;
            end
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    // checks
    `ASSERT_NEVER(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid && !r_out_valid, "skid full with output empty")
    `ASSERT_CLK(a_last_ends_name, i_clk, i_rst_n, in_xfer && i_last_byte |=> !r_in_progress, "name still open after last byte")
    `ASSERT_CLK(a_byte_opens_name, i_clk, i_rst_n, in_xfer && !i_last_byte |=> r_in_progress, "name not open after inner byte")
    `ASSERT_NEVER(a_col_row0_clear, i_clk, i_rst_n, r_col[0], "empty pattern prefix matched a nonempty name")

endmodule

/* bench/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wnm_pkg::*;

    typedef logic [7:0] t_bytes[$];

    localparam logic [7:0] BRACKET_OPEN = "[";
    localparam logic [7:0] CHAR_A       = "a";

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_PATTERN_LENGTH;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [7:0]            i_name_byte = '0;
    logic                  i_last_byte = 1'b0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic                  o_matched;

    // local copy of the matcher: registers, dp column, name state
    logic [5:0]            cfg_length = '0;
    logic [CFG_DATA_W-1:0] cfg_words [CFG_WORDS];
    t_column               dp_column = '0;
    logic                  name_open = 1'b0;

    logic                  pending_matches[$];
    logic                  hit_flag;
    logic                  want_match;
    int                    err_count = 0;
    int                    items_sent = 0;
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;

    wildcard_name_match_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_name_byte (i_name_byte),
        .i_last_byte (i_last_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_matched   (o_matched)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        for (int w = 0; w < CFG_WORDS; w++) cfg_words[w] = '0;
    end

    function automatic logic [7:0] pattern_char(int k);
        return cfg_words[k / 8][(k % 8) * 8 +: 8];
    endfunction

    // one byte through the dp column, returns the match bit at the pattern end
    function automatic logic glob_column_step(logic [7:0] b, logic last);
        int         len;
        int         i;
        logic       all_stars;
        logic [7:0] pc;
        t_column    prev;
        t_column    nxt;
        len = (cfg_length > PATTERN_MAX_BYTES) ? PATTERN_MAX_BYTES : int'(cfg_length);
        if (!name_open) begin
            // fresh name: bit 0 plus every all-star prefix
            prev = '0;
            prev[0] = 1'b1;
            all_stars = 1'b1;
            for (i = 1; i <= len; i++) begin
                all_stars = all_stars && (pattern_char(i - 1) == GLOB_ANY_RUN);
                prev[i] = all_stars;
            end
        end else begin
            prev = dp_column;
        end
        nxt = '0;
        for (i = 1; i <= len; i++) begin
            pc = pattern_char(i - 1);
            if (pc == GLOB_ANY_RUN)
                nxt[i] = prev[i] | nxt[i - 1];
            else if (pc == GLOB_ONE)
                nxt[i] = prev[i - 1];
            else
                nxt[i] = prev[i - 1] && (pc == b);
        end
        if (last) begin
            dp_column = '0;
            name_open = 1'b0;
        end else begin
            dp_column = nxt;
            name_open = 1'b1;
        end
        return nxt[len];
    endfunction

    // watch every transfer: predict on input, compare on output
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_PATTERN_LENGTH: cfg_length = i_cfg_data[5:0];
                    CFG_PATTERN_WORD_0: cfg_words[0] = i_cfg_data;
                    CFG_PATTERN_WORD_1: cfg_words[1] = i_cfg_data;
                    CFG_PATTERN_WORD_2: cfg_words[2] = i_cfg_data;
                    CFG_PATTERN_WORD_3: cfg_words[3] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                hit_flag = glob_column_step(i_name_byte, i_last_byte);
                if (i_last_byte) pending_matches = {pending_matches, hit_flag};
            end
            if (o_valid && i_ready) begin
                if (pending_matches.size() == 0) begin
                    $error("unexpected result transfer: matched=%0b", o_matched);
                    err_count++;
                end else begin
                    want_match = pending_matches.pop_front();
                    if (o_matched !== want_match) begin
                        $error("matched: expected %0b, actual %0b", want_match, o_matched);
                        err_count++;
                    end
                end
            end
        end
    end

    // single config transfer, channel dropped for one cycle afterwards
    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // load pattern bytes (0xff past the given bytes) and the length register
    task automatic set_pattern(input t_bytes pat, input logic [5:0] len);
        logic [CFG_DATA_W-1:0] word;
        logic [CFG_DATA_W-1:0] len_data;
        for (int w = 0; w < CFG_WORDS; w++) begin
            word = '1;
            for (int k = 0; k < 8; k++)
                if (w * 8 + k < pat.size()) word[k * 8 +: 8] = pat[w * 8 + k];
            write_reg(t_cfg_index'(CFG_PATTERN_WORD_0 + w), word);
        end
        // upper bits of the length write carry noise
        len_data = {$urandom, $urandom};
        len_data[5:0] = len;
        write_reg(CFG_PATTERN_LENGTH, len_data);
    endtask

    // one name byte; valid stays up unless a gap is taken
    task automatic put_byte(input logic [7:0] b, input logic last);
        i_valid     <= 1'b1;
        i_name_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
    endtask

    task automatic send_name(input t_bytes nm);
        for (int k = 0; k < nm.size(); k++) put_byte(nm[k], k == nm.size() - 1);
    endtask

    // hold the input until every predicted result has come back
    task automatic wait_results_drained();
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_matches.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_matches.size() != 0) begin
            $error("results still missing: %0d", pending_matches.size());
            err_count++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_bytes str_bytes(string s);
        t_bytes q;
        for (int k = 0; k < s.len(); k++) q = {q, 8'(s[k])};
        return q;
    endfunction

    function automatic logic [7:0] random_pattern_char();
        int r;
        r = $urandom_range(99);
        if (r < 22) return GLOB_ANY_RUN;
        if (r < 37) return GLOB_ONE;
        if (r < 45) return BRACKET_OPEN;
        if (r < 90) return CHAR_A + 8'($urandom_range(2));
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] random_name_char();
        int r;
        r = $urandom_range(99);
        if (r < 60) return CHAR_A + 8'($urandom_range(2));
        if (r < 70) return BRACKET_OPEN;
        return 8'($urandom_range(255));
    endfunction

    // mostly names that fit the pattern, some damaged, some pure noise
    function automatic t_bytes make_name(t_bytes pat, int eff);
        t_bytes nm;
        int     mode;
        int     n;
        mode = $urandom_range(99);
        if (mode < 10) begin
            n = $urandom_range(12, 1);
            repeat (n) nm = {nm, 8'($urandom_range(255))};
            return nm;
        end
        for (int k = 0; k < eff; k++) begin
            if (pat[k] == GLOB_ANY_RUN) begin
                n = $urandom_range(3);
                repeat (n) nm = {nm, random_name_char()};
            end else if (pat[k] == GLOB_ONE) begin
                nm = {nm, 8'($urandom_range(255))};
            end else begin
                nm = {nm, pat[k]};
            end
        end
        if (mode < 25 && nm.size() > 0) begin
            if ($urandom_range(1)) nm[$urandom_range(nm.size() - 1)] = random_name_char();
            else nm.pop_back();
        end
        if (nm.size() == 0) nm = {nm, random_name_char()};
        while (nm.size() > 48) nm.pop_back();
        return nm;
    endfunction

    // reset leaves an empty pattern, nothing can match
    task automatic test_empty_pattern();
        send_name(str_bytes("x"));
        wait_results_drained();
    endtask

    // star, question mark, literal bracket, star prefixes, byte extremes
    task automatic test_glob_basics();
        t_bytes nm;
        set_pattern(str_bytes("*"), 6'd1);
        nm = {8'hFF};
        send_name(nm);
        wait_results_drained();
        set_pattern(str_bytes("?"), 6'd1);
        nm = {8'h00};
        send_name(nm);
        wait_results_drained();
        set_pattern(str_bytes("[*?"), 6'd3);
        send_name(str_bytes("[xy"));
        wait_results_drained();
        set_pattern(str_bytes("**a"), 6'd3);
        send_name(str_bytes("a"));
        wait_results_drained();
        set_pattern(str_bytes("abc"), 6'd3);
        send_name(str_bytes("abd"));
        wait_results_drained();
        set_pattern(str_bytes("a*"), 6'd2);
        send_name(str_bytes("abc"));
        wait_results_drained();
    endtask

    // length saturation at the maximum and pattern bytes past the length
    task automatic test_length_limits();
        t_bytes pat;
        repeat (PATTERN_MAX_BYTES - 1) pat = {pat, GLOB_ANY_RUN};
        pat = {pat, 8'("z")};
        set_pattern(pat, 6'd63);
        send_name(str_bytes("z"));
        send_name(str_bytes("y"));
        wait_results_drained();
        set_pattern(str_bytes("ab"), 6'd1);
        send_name(str_bytes("a"));
        wait_results_drained();
    endtask

    // pattern changes between two bytes of one name, column carries over
    task automatic test_config_mid_name();
        set_pattern(str_bytes("ab"), 6'd2);
        put_byte("a", 1'b0);
        wait_results_drained();
        set_pattern(str_bytes("a?"), 6'd2);
        put_byte("x", 1'b1);
        wait_results_drained();
    endtask

    // random patterns and name streams under each idling mix
    task automatic test_random_streams();
        int     idle_mix [4][2] = '{'{0, 0}, '{50, 0}, '{0, 50}, '{11, 11}};
        t_bytes pat;
        int     len;
        int     eff;
        int     start;
        for (int ph = 0; ph < 8; ph++) begin
            send_idle_pct  = idle_mix[ph % 4][0];
            recv_stall_pct = idle_mix[ph % 4][1];
            start = items_sent;
            while (items_sent - start < 220) begin
                pat.delete();
                repeat (PATTERN_MAX_BYTES) pat = {pat, random_pattern_char()};
                if ($urandom_range(99) < 8) len = $urandom_range(63, 32);
                else len = $urandom_range(10);
                eff = (len > PATTERN_MAX_BYTES) ? PATTERN_MAX_BYTES : len;
                set_pattern(pat, 6'(len));
                repeat (6) send_name(make_name(pat, eff));
                wait_results_drained();
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_pattern();
        test_glob_basics();
        test_length_limits();
        test_config_mid_name();
        test_random_streams();
        wait_results_drained();
        repeat (8) @(posedge i_clk);
        if (pending_matches.size() != 0) begin
            $error("expected results never arrived: %0d", pending_matches.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("PASS wildcard_name_match_top");
        end else begin
            $display("FAIL wildcard_name_match_top");
        end
        $finish;
    end

    // run-away guard
    initial begin
        #4000000;
        $display("FAIL wildcard_name_match_top");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/wnm_pkg.sv
src/wildcard_name_match_top.sv
bench/tb_top.sv
